[rtl/ckalu_pkg.sv]
// ----------------------------------------------------------------------------
// ckalu_pkg
// Types and codes shared by the checked 64-bit scalar ALU.
// ----------------------------------------------------------------------------
package ckalu_pkg;

    localparam int unsigned DataW  = 64;
    localparam int unsigned HalfW  = DataW / 2;
    localparam int unsigned FuncW  = 3;
    localparam int unsigned CountW = 3;
    localparam int unsigned StatW  = 3;

    localparam logic [FuncW-1:0] OP_OPAQUE = 3'd0;
    localparam logic [FuncW-1:0] OP_CONST  = 3'd1;
    localparam logic [FuncW-1:0] OP_COPY   = 3'd2;
    localparam logic [FuncW-1:0] OP_ADD    = 3'd3;
    localparam logic [FuncW-1:0] OP_SUB    = 3'd4;
    localparam logic [FuncW-1:0] OP_MUL    = 3'd5;
    localparam logic [FuncW-1:0] OP_EQ     = 3'd6;
    localparam logic [FuncW-1:0] OP_LT     = 3'd7;

    localparam logic [StatW-1:0] ST_OK       = 3'd0;
    localparam logic [StatW-1:0] ST_SHAPE    = 3'd1;
    localparam logic [StatW-1:0] ST_COUNT    = 3'd2;
    localparam logic [StatW-1:0] ST_OPAQUE   = 3'd3;
    localparam logic [StatW-1:0] ST_OVERFLOW = 3'd4;

    localparam logic [CountW-1:0] USES_CONST  = 3'd0;
    localparam logic [CountW-1:0] USES_COPY   = 3'd1;
    localparam logic [CountW-1:0] USES_BINARY = 3'd2;

    localparam logic [DataW-1:0] SIGN_BIT = {1'b1, {(DataW-1){1'b0}}};

    typedef struct packed {
        logic [FuncW-1:0]         func;
        logic [CountW-1:0]        num_uses;
        logic                     has_def;
        logic                     has_imm;
        logic signed [DataW-1:0]  imm_value;
        logic [CountW-1:0]        operand_count;
        logic signed [DataW-1:0]  operand_a;
        logic signed [DataW-1:0]  operand_b;
    } cmd_t;

    typedef struct packed {
        logic signed [DataW-1:0]  result_value;
        logic [StatW-1:0]         status;
    } rsp_t;

endpackage

[rtl/checked_scalar_alu_i64.sv]
// ----------------------------------------------------------------------------
// checked_scalar_alu_i64
// Checked 64-bit scalar ALU: shape and operand-count checks, constant, copy,
// add, subtract, multiply with exact overflow detection, equal and signed less-than.
// ----------------------------------------------------------------------------
// An accepted transaction moves through the stage-one, stage-two and stage-three
// registers into the output register, which drives done and the result together.
// Throughput: one transaction per cycle; busy is always low because the
// four-stage pipeline (decode, 32x32 partial products, partial sums, final
// check) never holds, and the receiver takes every result as it appears.
// Reset clears all pipeline valid bits, so no stale result appears after reset.
module checked_scalar_alu_i64 (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ckalu_pkg::cmd_t cmd,
    output logic            done,
    output ckalu_pkg::rsp_t rsp
);
    import ckalu_pkg::*;

    // Stage 1: checks, simple operations, operand magnitudes.
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_mul_reg, s1_mul_next;
    logic                s1_neg_reg, s1_neg_next;
    logic [StatW-1:0]    s1_status_reg, s1_status_next;
    logic [DataW-1:0]    s1_value_reg, s1_value_next;
    logic [DataW-1:0]    s1_ma_reg, s1_ma_next;
    logic [DataW-1:0]    s1_mb_reg, s1_mb_next;

    // Stage 2: partial products.
    logic                s2_valid_reg;
    logic                s2_mul_reg, s2_neg_reg;
    logic [StatW-1:0]    s2_status_reg;
    logic [DataW-1:0]    s2_value_reg;
    logic [DataW-1:0]    s2_ll_reg, s2_lh_reg, s2_hl_reg, s2_hh_reg;
    logic [DataW-1:0]    s2_ll_next, s2_lh_next, s2_hl_next, s2_hh_next;

    // Stage 3: partial sums of the 128-bit product.
    logic                s3_valid_reg;
    logic                s3_mul_reg, s3_neg_reg;
    logic [StatW-1:0]    s3_status_reg;
    logic [DataW-1:0]    s3_value_reg;
    logic [HalfW+1:0]    s3_mid_reg, s3_mid_next;
    logic [HalfW-1:0]    s3_ll_lo_reg;
    logic [DataW-1:0]    s3_hi_reg, s3_hi_next;

    // Stage 4: output register.
    logic                done_reg;
    rsp_t                rsp_reg, rsp_next;

    logic                shape_ok;
    logic [DataW-1:0]    op_a, op_b, sum, diff;
    logic                add_ovf, sub_ovf;
    logic [DataW-1:0]    lo;
    logic                hi_nz, mul_ovf;

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1
    // ------------------------------------------------------------------
    always_comb
    begin
        op_a = cmd.operand_a;
        op_b = cmd.operand_b;
        sum  = op_a + op_b;
        diff = op_a - op_b;
        add_ovf = (~(op_a[DataW-1] ^ op_b[DataW-1])) & (op_a[DataW-1] ^ sum[DataW-1]);
        sub_ovf = (op_a[DataW-1] ^ op_b[DataW-1]) & (op_a[DataW-1] ^ diff[DataW-1]);

        unique case (cmd.func)
            OP_OPAQUE: shape_ok = !cmd.has_imm;
            OP_CONST:  shape_ok = (cmd.num_uses == USES_CONST) && cmd.has_def
                                  && cmd.has_imm;
            OP_COPY:   shape_ok = (cmd.num_uses == USES_COPY) && cmd.has_def
                                  && !cmd.has_imm;
            default:   shape_ok = (cmd.num_uses == USES_BINARY) && cmd.has_def
                                  && !cmd.has_imm;
        endcase

        s1_value_next = '0;
        case (cmd.func)
            OP_CONST: s1_value_next = cmd.imm_value;
            OP_COPY:  s1_value_next = op_a;
            OP_ADD:   s1_value_next = sum;
            OP_SUB:   s1_value_next = diff;
            OP_EQ:    s1_value_next = {{(DataW-1){1'b0}}, (op_a == op_b)};
            OP_LT:    s1_value_next = {{(DataW-1){1'b0}},
                                       ((op_a ^ SIGN_BIT) < (op_b ^ SIGN_BIT))};
            default:  s1_value_next = '0;
        endcase

        if (!shape_ok)
            s1_status_next = ST_SHAPE;
        else if (cmd.operand_count != cmd.num_uses)
            s1_status_next = ST_COUNT;
        else if (cmd.func == OP_OPAQUE)
            s1_status_next = ST_OPAQUE;
        else if ((cmd.func == OP_ADD && add_ovf) || (cmd.func == OP_SUB && sub_ovf))
            s1_status_next = ST_OVERFLOW;
        else
            s1_status_next = ST_OK;

        if (s1_status_next != ST_OK)
            s1_value_next = '0;

        s1_valid_next = start && !busy;
        s1_mul_next   = (cmd.func == OP_MUL);
        s1_neg_next   = op_a[DataW-1] ^ op_b[DataW-1];
        s1_ma_next    = op_a[DataW-1] ? (-op_a) : op_a;
        s1_mb_next    = op_b[DataW-1] ? (-op_b) : op_b;
    end

    // ------------------------------------------------------------------
    // Stage 2: four 32x32 unsigned products of the magnitudes.
    // ------------------------------------------------------------------
    always_comb
    begin
        s2_ll_next = {{HalfW{1'b0}}, s1_ma_reg[HalfW-1:0]}
                   * {{HalfW{1'b0}}, s1_mb_reg[HalfW-1:0]};
        s2_lh_next = {{HalfW{1'b0}}, s1_ma_reg[HalfW-1:0]}
                   * {{HalfW{1'b0}}, s1_mb_reg[DataW-1:HalfW]};
        s2_hl_next = {{HalfW{1'b0}}, s1_ma_reg[DataW-1:HalfW]}
                   * {{HalfW{1'b0}}, s1_mb_reg[HalfW-1:0]};
        s2_hh_next = {{HalfW{1'b0}}, s1_ma_reg[DataW-1:HalfW]}
                   * {{HalfW{1'b0}}, s1_mb_reg[DataW-1:HalfW]};
    end

    // ------------------------------------------------------------------
    // Stage 3: middle column and the upper word without the middle carry.
    // The upper word cannot wrap since the full product fits in 128 bits.
    // ------------------------------------------------------------------
    always_comb
    begin
        s3_mid_next = {2'b00, s2_ll_reg[DataW-1:HalfW]}
                    + {2'b00, s2_lh_reg[HalfW-1:0]}
                    + {2'b00, s2_hl_reg[HalfW-1:0]};
        s3_hi_next  = s2_hh_reg
                    + {{HalfW{1'b0}}, s2_lh_reg[DataW-1:HalfW]}
                    + {{HalfW{1'b0}}, s2_hl_reg[DataW-1:HalfW]};
    end

    // ------------------------------------------------------------------
    // Stage 4: range check of the product, sign, final select.
    // ------------------------------------------------------------------
    always_comb
    begin
        lo    = {s3_mid_reg[HalfW-1:0], s3_ll_lo_reg};
        hi_nz = (s3_hi_reg != '0) || (s3_mid_reg[HalfW+1:HalfW] != 2'b00);
        // A negative product may reach the most negative value exactly.
        mul_ovf = hi_nz || (s3_neg_reg ? (lo > SIGN_BIT) : lo[DataW-1]);

        rsp_next.result_value = s3_value_reg;
        rsp_next.status       = s3_status_reg;
        if (s3_mul_reg && s3_status_reg == ST_OK)
        begin
            if (mul_ovf)
            begin
                rsp_next.result_value = '0;
                rsp_next.status       = ST_OVERFLOW;
            end
            else
            begin
                rsp_next.result_value = s3_neg_reg ? (-lo) : lo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mul_reg    <= s1_mul_next;
        s1_neg_reg    <= s1_neg_next;
        s1_status_reg <= s1_status_next;
        s1_value_reg  <= s1_value_next;
        s1_ma_reg     <= s1_ma_next;
        s1_mb_reg     <= s1_mb_next;

        s2_mul_reg    <= s1_mul_reg;
        s2_neg_reg    <= s1_neg_reg;
        s2_status_reg <= s1_status_reg;
        s2_value_reg  <= s1_value_reg;
        s2_ll_reg     <= s2_ll_next;
        s2_lh_reg     <= s2_lh_next;
        s2_hl_reg     <= s2_hl_next;
        s2_hh_reg     <= s2_hh_next;

        s3_mul_reg    <= s2_mul_reg;
        s3_neg_reg    <= s2_neg_reg;
        s3_status_reg <= s2_status_reg;
        s3_value_reg  <= s2_value_reg;
        s3_mid_reg    <= s3_mid_next;
        s3_ll_lo_reg  <= s2_ll_reg[HalfW-1:0];
        s3_hi_reg     <= s3_hi_next;

        rsp_reg       <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Every accepted transaction produces a result, signalled by done.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result did not appear four cycles after start");

    // A result with an error status always carries a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.result_value == '0))
        else $error("nonzero value with error status");

    // A non-multiply transaction leaves the last stage with its stage-one status.
    a_status_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_mul_reg) |=> (rsp.status == $past(s3_status_reg)))
        else $error("status changed in the product stages");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == ST_OK || rsp.status == ST_SHAPE
                  || rsp.status == ST_COUNT || rsp.status == ST_OPAQUE
                  || rsp.status == ST_OVERFLOW))
        else $error("undefined status code");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the checked 64-bit scalar ALU. Directed transactions
// cover shape and operand-count errors, the opaque opcode and arithmetic
// edges. Random phases then run at full rate, with sparse issue and with light
// gaps. Every result is compared with a local model of the ALU.
// ----------------------------------------------------------------------------
module tb;
    import ckalu_pkg::*;

    localparam int unsigned HalfPeriod = 4;
    localparam int unsigned StallLimit = 1000;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned MaxReports = 10;

    localparam logic [DataW-1:0] I64_MIN = SIGN_BIT;
    localparam logic [DataW-1:0] I64_MAX = ~SIGN_BIT;
    localparam logic [DataW-1:0] NEG_ONE = '1;

    typedef struct {
        cmd_t instr;
        rsp_t rsp;
    } expect_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic done;
    rsp_t rsp;

    expect_t pending_results[$];
    expect_t oldest;
    int      issue_gap_pct;
    int      instr_sent;
    int      results_checked;
    int      mismatch_count;
    int      stall_cycles;
    int      status_seen[5];

    checked_scalar_alu_i64 i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #HalfPeriod clk = 1'b1;
        #HalfPeriod clk = 1'b0;
    end

    // Result of one instruction as the ALU must compute it.
    function automatic rsp_t predict_rsp(input cmd_t c);
        logic                 shape_good;
        logic [DataW:0]       wide;
        logic [2*DataW-1:0]   prod;
        rsp_t                 r;
        r.result_value = '0;
        r.status       = ST_OK;
        case (c.func)
            OP_OPAQUE: shape_good = !c.has_imm;
            OP_CONST:  shape_good = c.num_uses == USES_CONST && c.has_def && c.has_imm;
            OP_COPY:   shape_good = c.num_uses == USES_COPY && c.has_def && !c.has_imm;
            default:   shape_good = c.num_uses == USES_BINARY && c.has_def && !c.has_imm;
        endcase
        if (!shape_good)
            r.status = ST_SHAPE;
        else if (c.operand_count != c.num_uses)
            r.status = ST_COUNT;
        else
        begin
            case (c.func)
                OP_OPAQUE: r.status = ST_OPAQUE;
                OP_CONST:  r.result_value = c.imm_value;
                OP_COPY:   r.result_value = c.operand_a;
                OP_ADD:
                begin
                    wide = {c.operand_a[DataW-1], c.operand_a}
                         + {c.operand_b[DataW-1], c.operand_b};
                    r.result_value = wide[DataW-1:0];
                    if (wide[DataW] != wide[DataW-1])
                        r.status = ST_OVERFLOW;
                end
                OP_SUB:
                begin
                    wide = {c.operand_a[DataW-1], c.operand_a}
                         - {c.operand_b[DataW-1], c.operand_b};
                    r.result_value = wide[DataW-1:0];
                    if (wide[DataW] != wide[DataW-1])
                        r.status = ST_OVERFLOW;
                end
                OP_MUL:
                begin
                    // Sign-extended operands give the exact product in 128 bits.
                    prod = {{DataW{c.operand_a[DataW-1]}}, c.operand_a}
                         * {{DataW{c.operand_b[DataW-1]}}, c.operand_b};
                    r.result_value = prod[DataW-1:0];
                    if (prod[2*DataW-1:DataW-1] != {(DataW+1){prod[DataW-1]}})
                        r.status = ST_OVERFLOW;
                end
                OP_EQ:     r.result_value = (c.operand_a == c.operand_b) ? 64'd1 : 64'd0;
                default:
                    r.result_value = ($signed(c.operand_a) < $signed(c.operand_b)) ? 64'd1 : 64'd0;
            endcase
        end
        if (r.status != ST_OK)
            r.result_value = '0;
        return r;
    endfunction

    function automatic cmd_t build_instr(input logic [FuncW-1:0] func,
                                         input logic [CountW-1:0] uses,
                                         input logic def, input logic imm,
                                         input logic [DataW-1:0] immv,
                                         input logic [CountW-1:0] cnt,
                                         input logic [DataW-1:0] a,
                                         input logic [DataW-1:0] b);
        cmd_t c;
        c.func          = func;
        c.num_uses      = uses;
        c.has_def       = def;
        c.has_imm       = imm;
        c.imm_value     = immv;
        c.operand_count = cnt;
        c.operand_a     = a;
        c.operand_b     = b;
        return c;
    endfunction

    // Operand mix weighted toward values where overflow and sign matter.
    function automatic logic [DataW-1:0] rand_operand();
        logic [DataW-1:0] v;
        case ($urandom_range(7))
            0, 1, 2: v = {$urandom, $urandom};
            3:       v = {{(DataW-16){1'b0}}, 16'($urandom)} - 64'd32768;
            4:
            begin
                case ($urandom_range(4))
                    0: v = I64_MIN;
                    1: v = I64_MAX;
                    2: v = '0;
                    3: v = NEG_ONE;
                    default: v = 64'd1;
                endcase
            end
            5:       v = {{32{1'b0}}, 32'($urandom)} - 64'h8000_0000;
            6:       v = (64'd1 << $urandom_range(63)) - 64'($urandom_range(3));
            default: v = I64_MAX - 64'($urandom_range(7));
        endcase
        if ($urandom_range(1) == 1)
            v = -v;
        return v;
    endfunction

    // Mostly well-formed instructions with random content, some noise.
    function automatic cmd_t random_instr();
        cmd_t c;
        c = build_instr(3'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
                        rand_operand(), 3'($urandom), rand_operand(), rand_operand());
        if ($urandom_range(99) < 85)
        begin
            c.has_def = (c.func == OP_OPAQUE) ? 1'($urandom) : 1'b1;
            c.has_imm = (c.func == OP_CONST);
            case (c.func)
                OP_OPAQUE: ;
                OP_CONST:  c.num_uses = USES_CONST;
                OP_COPY:   c.num_uses = USES_COPY;
                default:   c.num_uses = USES_BINARY;
            endcase
            if ($urandom_range(99) < 90)
                c.operand_count = c.num_uses;
        end
        return c;
    endfunction

    task automatic send_instr(input cmd_t c);
        expect_t e;
        @(negedge clk);
        while ($urandom_range(99) < issue_gap_pct)
        begin
            start <= 1'b0;
            cmd   <= random_instr();
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        e.instr = c;
        e.rsp   = predict_rsp(c);
        pending_results = {pending_results, e};
        instr_sent++;
    endtask

    task automatic run_random(input int count, input int gap_pct);
        issue_gap_pct = gap_pct;
        repeat (count)
            send_instr(random_instr());
    endtask

    task automatic test_shape_checks();
        issue_gap_pct = 8;
        send_instr(build_instr(OP_OPAQUE, 3'd2, 1'b1, 1'b1, '0, 3'd2, '0, '0));
        send_instr(build_instr(OP_CONST, USES_CONST, 1'b1, 1'b0, I64_MAX, 3'd0, '0, '0));
        send_instr(build_instr(OP_COPY, USES_BINARY, 1'b1, 1'b0, '0, 3'd2, 64'd5, '0));
        send_instr(build_instr(OP_LT, USES_BINARY, 1'b0, 1'b0, '0, 3'd2, NEG_ONE, '0));
    endtask

    task automatic test_count_checks();
        issue_gap_pct = 8;
        send_instr(build_instr(OP_ADD, USES_BINARY, 1'b1, 1'b0, '0, 3'd3, 64'd1, 64'd2));
        // Both counts saturated: the count check passes and the opaque check fires.
        send_instr(build_instr(OP_OPAQUE, 3'd7, 1'b1, 1'b0, NEG_ONE, 3'd7, '0, '0));
        send_instr(build_instr(OP_OPAQUE, 3'd0, 1'b0, 1'b0, '0, 3'd0, '0, '0));
        send_instr(build_instr(OP_OPAQUE, 3'd3, 1'b0, 1'b0, '0, 3'd5, '0, '0));
    endtask

    task automatic test_arith_edges();
        issue_gap_pct = 0;
        // Operands that an opcode ignores carry junk on purpose.
        send_instr(build_instr(OP_CONST, USES_CONST, 1'b1, 1'b1, I64_MAX, 3'd0, NEG_ONE, 64'd9));
        send_instr(build_instr(OP_CONST, USES_CONST, 1'b1, 1'b1, I64_MIN, 3'd0, 64'd3, I64_MAX));
        send_instr(build_instr(OP_COPY, USES_COPY, 1'b1, 1'b0, NEG_ONE, 3'd1, I64_MIN, I64_MAX));
        send_instr(build_instr(OP_ADD, USES_BINARY, 1'b1, 1'b0, '0, 3'd2, I64_MAX, 64'd1));
        send_instr(build_instr(OP_ADD, USES_BINARY, 1'b1, 1'b0, '0, 3'd2, I64_MIN, NEG_ONE));
        send_instr(build_instr(OP_SUB, USES_BINARY, 1'b1, 1'b0, '0, 3'd2, I64_MIN, 64'd1));
        send_instr(build_instr(OP_SUB, USES_BINARY, 1'b1, 1'b0, '0, 3'd2, '0, I64_MIN));
        send_instr(build_instr(OP_MUL, USES_BINARY, 1'b1, 1'b0, '0, 3'd2, I64_MIN, '0));
        send_instr(build_instr(OP_MUL, USES_BINARY, 1'b1, 1'b0, '0, 3'd2, I64_MIN, NEG_ONE));
        send_instr(build_instr(OP_MUL, USES_BINARY, 1'b1, 1'b0, '0, 3'd2,
                               64'h4000_0000_0000_0000, -64'd2));
        // The largest square below the limit, then the first one above it.
        send_instr(build_instr(OP_MUL, USES_BINARY, 1'b1, 1'b0, '0, 3'd2,
                               64'd3037000499, 64'd3037000499));
        send_instr(build_instr(OP_MUL, USES_BINARY, 1'b1, 1'b0, '0, 3'd2,
                               64'd3037000500, 64'd3037000500));
        send_instr(build_instr(OP_EQ, USES_BINARY, 1'b1, 1'b0, '0, 3'd2, I64_MIN, I64_MIN));
        send_instr(build_instr(OP_LT, USES_BINARY, 1'b1, 1'b0, '0, 3'd2, NEG_ONE, '0));
        send_instr(build_instr(OP_LT, USES_BINARY, 1'b1, 1'b0, '0, 3'd2, I64_MAX, I64_MIN));
    endtask

    task automatic test_full_rate();
        run_random(550, 0);
    endtask

    task automatic test_sparse_issue();
        run_random(550, 53);
    endtask

    task automatic test_light_gaps();
        run_random(550, 8);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MaxReports)
                    $display("%0t: unexpected result value=%h status=%0d",
                             $realtime, rsp.result_value, rsp.status);
            end
            else
            begin
                oldest = pending_results.pop_front();
                results_checked++;
                if (oldest.rsp.status < 5)
                    status_seen[oldest.rsp.status]++;
                if (rsp.result_value !== oldest.rsp.result_value
                    || rsp.status !== oldest.rsp.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MaxReports)
                        $display("%0t: func=%0d a=%h b=%h exp %h/%0d got %h/%0d",
                                 $realtime, oldest.instr.func, oldest.instr.operand_a,
                                 oldest.instr.operand_b, oldest.rsp.result_value,
                                 oldest.rsp.status, rsp.result_value, rsp.status);
                end
            end
        end
    end

    // Ends a hung run: no transaction accepted and no result seen for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= StallLimit)
            begin
                $display("Timeout after %0d idle cycles, %0d results outstanding",
                         stall_cycles, pending_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        cmd             = '0;
        issue_gap_pct   = 0;
        instr_sent      = 0;
        results_checked = 0;
        mismatch_count  = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_shape_checks();
        test_count_checks();
        test_arith_edges();
        test_full_rate();
        test_sparse_issue();
        test_light_gaps();

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Sent %0d instructions (directed, full rate, sparse, light gaps), checked %0d",
                 instr_sent, results_checked);
        $display("Statuses: ok %0d, shape %0d, count %0d, opaque %0d, overflow %0d; bad %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/ckalu_pkg.sv
rtl/checked_scalar_alu_i64.sv
tb/tb.sv
